// ----- rtl/core/rhsv_pkg.sv -----
// ----------------------------------------------------------------------------
// rhsv_pkg - shared types and constants
// Payload structs, queue entry and status types, and the fixed constants of
// the RGB to hue / saturation / intensity / value change filter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_SINGLE = 2'd0;
  localparam mode_t MODE_RGB    = 2'd1;
  localparam mode_t MODE_RGBW   = 2'd2;

  localparam int BYTE_W = 8;
  localparam int SUM_W  = 10;
  localparam int NUM_W  = 18;
  localparam int DEN_W  = 10;
  localparam int QUO_W  = 9;
  localparam int PCT_W  = 7;

  // Divider retires two quotient bits a cycle
  localparam int DIV_STEPS = NUM_W / 2;

  localparam int DEG_60    = 60;
  localparam int DEG_120   = 120;
  localparam int DEG_240   = 240;
  localparam int HUE_FULL  = 360;
  localparam int PCT_FULL  = 100;
  localparam int BYTE_FULL = 255;
  localparam int SUM_FULL  = 765;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [DEN_W-1:0]  den_t;
  typedef logic [QUO_W-1:0]  quo_t;
  typedef logic [PCT_W-1:0]  pct_t;

  typedef struct packed {
    byte_t chan_byte0;
    byte_t chan_byte1;
    byte_t chan_byte2;
    byte_t chan_byte3;
  } pix_t;

  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t white;
    logic  switch_on;
    quo_t  hue_deg;
    pct_t  sat_intensity_pct;
    pct_t  sat_value_pct;
    pct_t  intensity_pct;
    pct_t  value_pct;
  } res_t;

  // One changed frame, classified and waiting for the back end
  typedef struct packed {
    byte_t r;
    byte_t g;
    byte_t b;
    byte_t w;
    logic  switch_on;
    byte_t mx;
    byte_t mn;
    byte_t c;
    sum_t  sum;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- rtl/core/rgb_to_hsv_hsi_change_filter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsi_change_filter - RGB to HSV / HSI change filter
// Front end maps and filters frames, a job queue decouples it from the
// back end, which converts through one shared two-bit-a-cycle divider.
// ----------------------------------------------------------------------------
// Each changed frame is popped and loaded, then runs five divisions in turn
// through the shared divider; the back end takes no new job until its
// result word is loaded.
// Unchanged frames are dropped at one a cycle while the queue has room.
// Reset (rst, synchronous): mode RGB, last frame zero, queue and result empty.
module rgb_to_hsv_hsi_change_filter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode_we,
  input  rhsv_pkg::mode_t mode_data,
  input  logic            pix_valid,
  output logic            pix_stall,
  input  rhsv_pkg::pix_t  pix,
  output logic            res_valid,
  input  logic            res_stall,
  output rhsv_pkg::res_t  res
);

  rhsv_pkg::queue_status_t q_status;
  rhsv_pkg::job_t          push_job, pop_job;
  logic                    push, pop;

  rhsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mode_we   (mode_we),
    .mode_data (mode_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  rhsv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  rhsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop       (pop),
    .pop_job   (pop_job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ----- rtl/core/rhsv_front.sv -----
// ----------------------------------------------------------------------------
// rhsv_front - mode mapping and change detection
// Maps the channel bytes by mode, drops frames equal to the last one, and
// queues changed frames with their max, min, chroma and sum.
// ----------------------------------------------------------------------------
module rhsv_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    mode_we,
  input  rhsv_pkg::mode_t         mode_data,
  input  logic                    pix_valid,
  output logic                    pix_stall,
  input  rhsv_pkg::pix_t          pix,
  input  rhsv_pkg::queue_status_t q_status,
  output logic                    push,
  output rhsv_pkg::job_t          push_job
);

  rhsv_pkg::mode_t mode;
  rhsv_pkg::byte_t last_red, last_green, last_blue, last_white;
  rhsv_pkg::byte_t r, g, b, w, mx, mn;
  logic            accept, changed;

  always_comb begin
    r = '0;
    g = '0;
    b = '0;
    w = '0;
    case (mode)
      rhsv_pkg::MODE_SINGLE: begin
        w = pix.chan_byte0;
      end
      rhsv_pkg::MODE_RGB: begin
        r = pix.chan_byte0;
        g = pix.chan_byte1;
        b = pix.chan_byte2;
      end
      rhsv_pkg::MODE_RGBW: begin
        r = pix.chan_byte0;
        g = pix.chan_byte1;
        b = pix.chan_byte2;
        w = pix.chan_byte3;
      end
      default: begin
        r = '0;
      end
    endcase
  end

  always_comb begin
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
  end

  assign changed   = (r != last_red) || (g != last_green) ||
                     (b != last_blue) || (w != last_white);
  assign pix_stall = q_status.full;
  assign accept    = pix_valid && !q_status.full;
  assign push      = accept && changed;

  always_comb begin
    push_job.r         = r;
    push_job.g         = g;
    push_job.b         = b;
    push_job.w         = w;
    push_job.switch_on = (r == 8'hFF) || (g == 8'hFF) || (b == 8'hFF) || (w == 8'hFF);
    push_job.mx        = mx;
    push_job.mn        = mn;
    push_job.c         = mx - mn;
    push_job.sum       = {2'b00, r} + {2'b00, g} + {2'b00, b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= rhsv_pkg::MODE_RGB;
      last_red   <= '0;
      last_green <= '0;
      last_blue  <= '0;
      last_white <= '0;
    end else begin
      if (mode_we) begin
        mode <= mode_data;
      end
      // hold the last frame only when it changed
      if (push) begin
        last_red   <= r;
        last_green <= g;
        last_blue  <= b;
        last_white <= w;
      end
    end
  end

endmodule

// ----- rtl/core/rhsv_queue.sv -----
// ----------------------------------------------------------------------------
// rhsv_queue - job queue between front and back end
// Small register queue of classified frames; full and empty as status.
// ----------------------------------------------------------------------------
module rhsv_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rhsv_pkg::job_t          push_job,
  input  logic                    pop,
  output rhsv_pkg::job_t          pop_job,
  output rhsv_pkg::queue_status_t q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rhsv_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_job        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/rhsv_div.sv -----
// ----------------------------------------------------------------------------
// rhsv_div - iterative unsigned divider
// Restoring division, two quotient bits a cycle; done pulses when the
// quotient is ready.
// ----------------------------------------------------------------------------
module rhsv_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rhsv_pkg::num_t num,
  input  rhsv_pkg::den_t den,
  output logic           done,
  output rhsv_pkg::quo_t quo
);

  localparam int CNT_W = $clog2(rhsv_pkg::DIV_STEPS + 1);

  rhsv_pkg::num_t   acc, acc_next;
  rhsv_pkg::den_t   rem, rem_next, den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_comb begin
    logic [rhsv_pkg::DEN_W:0] sh;
    acc_next = acc;
    rem_next = rem;
    for (int i = 0; i < 2; i++) begin
      sh       = {rem_next, acc_next[rhsv_pkg::NUM_W-1]};
      acc_next = {acc_next[rhsv_pkg::NUM_W-2:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        sh          = sh - {1'b0, den_r};
        acc_next[0] = 1'b1;
      end
      rem_next = sh[rhsv_pkg::DEN_W-1:0];
    end
  end

  assign quo = acc[rhsv_pkg::QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(rhsv_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/rhsv_back.sv -----
// ----------------------------------------------------------------------------
// rhsv_back - conversion sequencer and result register
// Pops a job, runs hue, HSI saturation, HSV saturation, intensity and value
// through one shared divider, and holds the result word until taken.
// ----------------------------------------------------------------------------
module rhsv_back (
  input  logic                    clk,
  input  logic                    rst,
  input  rhsv_pkg::queue_status_t q_status,
  output logic                    pop,
  input  rhsv_pkg::job_t          pop_job,
  output logic                    res_valid,
  input  logic                    res_stall,
  output rhsv_pkg::res_t          res
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    OP_HUE,
    OP_SI,
    OP_SV,
    OP_INT,
    OP_VAL
  } op_t;

  state_t         state;
  op_t            op, op_next;
  rhsv_pkg::job_t job;
  rhsv_pkg::quo_t hue;
  rhsv_pkg::pct_t si, sv, ipct, vpct;
  rhsv_pkg::num_t num, n_r, n_g, n_b, n_c, n_mn, n_mx, n_sum;
  rhsv_pkg::den_t den;
  rhsv_pkg::quo_t quo;
  logic           div_start, div_done;
  logic           red_max, green_max, hue_neg, grey, mx_zero, res_load;

  assign n_r   = rhsv_pkg::num_t'(job.r);
  assign n_g   = rhsv_pkg::num_t'(job.g);
  assign n_b   = rhsv_pkg::num_t'(job.b);
  assign n_c   = rhsv_pkg::num_t'(job.c);
  assign n_mn  = rhsv_pkg::num_t'(job.mn);
  assign n_mx  = rhsv_pkg::num_t'(job.mx);
  assign n_sum = rhsv_pkg::num_t'(job.sum);

  // red wins ties over green, green over blue
  assign red_max   = (job.r == job.mx);
  assign green_max = !red_max && (job.g == job.mx);
  assign hue_neg   = red_max && (job.g < job.b);
  assign grey      = (job.c == '0);
  assign mx_zero   = (job.mx == '0);

  always_comb begin
    num = '0;
    den = '0;
    case (op)
      OP_HUE: begin
        den = rhsv_pkg::den_t'(job.c);
        if (hue_neg) begin
          // ceiling of the negative part, taken from 360 afterwards
          num = rhsv_pkg::num_t'(rhsv_pkg::DEG_60) * (n_b - n_g) + n_c - 1'b1;
        end else if (red_max) begin
          num = rhsv_pkg::num_t'(rhsv_pkg::DEG_60) * (n_g - n_b);
        end else if (green_max) begin
          num = rhsv_pkg::num_t'(rhsv_pkg::DEG_120) * n_c
              + rhsv_pkg::num_t'(rhsv_pkg::DEG_60) * n_b
              - rhsv_pkg::num_t'(rhsv_pkg::DEG_60) * n_r;
        end else begin
          num = rhsv_pkg::num_t'(rhsv_pkg::DEG_240) * n_c
              + rhsv_pkg::num_t'(rhsv_pkg::DEG_60) * n_r
              - rhsv_pkg::num_t'(rhsv_pkg::DEG_60) * n_g;
        end
      end
      OP_SI: begin
        num = rhsv_pkg::num_t'(rhsv_pkg::PCT_FULL) * (n_sum - rhsv_pkg::num_t'(3) * n_mn);
        den = job.sum;
      end
      OP_SV: begin
        num = rhsv_pkg::num_t'(rhsv_pkg::PCT_FULL) * n_c;
        den = rhsv_pkg::den_t'(job.mx);
      end
      OP_INT: begin
        num = rhsv_pkg::num_t'(rhsv_pkg::PCT_FULL) * n_sum;
        den = rhsv_pkg::den_t'(rhsv_pkg::SUM_FULL);
      end
      OP_VAL: begin
        num = rhsv_pkg::num_t'(rhsv_pkg::PCT_FULL) * n_mx;
        den = rhsv_pkg::den_t'(rhsv_pkg::BYTE_FULL);
      end
      default: begin
        num = '0;
      end
    endcase
  end

  always_comb begin
    case (op)
      OP_HUE:  op_next = OP_SI;
      OP_SI:   op_next = OP_SV;
      OP_SV:   op_next = OP_INT;
      OP_INT:  op_next = OP_VAL;
      default: op_next = OP_HUE;
    endcase
  end

  assign div_start = (state == S_START);
  assign pop       = (state == S_IDLE) && !q_status.empty;
  assign res_load  = (state == S_DONE) && (!res_valid || !res_stall);

  rhsv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_HUE;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            op    <= OP_HUE;
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            op    <= op_next;
            state <= (op == OP_VAL) ? S_DONE : S_START;
          end
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
    end
    if ((state == S_WAIT) && div_done) begin
      case (op)
        OP_HUE: begin
          if (grey) begin
            hue <= '0;
          end else if (hue_neg) begin
            hue <= rhsv_pkg::quo_t'(rhsv_pkg::HUE_FULL) - quo;
          end else begin
            hue <= quo;
          end
        end
        OP_SI:   si   <= grey ? '0 : quo[rhsv_pkg::PCT_W-1:0];
        OP_SV:   sv   <= mx_zero ? '0 : quo[rhsv_pkg::PCT_W-1:0];
        OP_INT:  ipct <= quo[rhsv_pkg::PCT_W-1:0];
        default: vpct <= quo[rhsv_pkg::PCT_W-1:0];
      endcase
    end
    if (res_load) begin
      res.red               <= job.r;
      res.green             <= job.g;
      res.blue              <= job.b;
      res.white             <= job.w;
      res.switch_on         <= job.switch_on;
      res.hue_deg           <= hue;
      res.sat_intensity_pct <= si;
      res.sat_value_pct     <= sv;
      res.intensity_pct     <= ipct;
      res.value_pct         <= vpct;
    end
  end

endmodule

// ----- rtl/core/rhsv_check.sv -----
// ----------------------------------------------------------------------------
// rhsv_check - port checker for the change filter
// Watches the result channel: hold under stall, ranges, switch flag, grey
// frames and that every delivered word differs from the one before.
// ----------------------------------------------------------------------------
module rhsv_check (
  input logic            clk,
  input logic            rst,
  input logic            res_valid,
  input logic            res_stall,
  input rhsv_pkg::res_t  res
);

  logic [31:0] last_rgbw;
  logic [31:0] cur_rgbw;
  logic        res_take;

  assign cur_rgbw = {res.red, res.green, res.blue, res.white};
  assign res_take = res_valid && !res_stall;

  // the block resets its last frame to zero, so start from zero too
  always_ff @(posedge clk) begin
    if (rst) begin
      last_rgbw <= '0;
    end else if (res_take) begin
      last_rgbw <= cur_rgbw;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  a_changed: assert property (@(posedge clk) disable iff (rst)
    res_take |-> cur_rgbw != last_rgbw)
    else $error("result repeats the previous frame");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.hue_deg <= 9'd359 && res.sat_intensity_pct <= 7'd100 &&
                  res.sat_value_pct <= 7'd100 && res.intensity_pct <= 7'd100 &&
                  res.value_pct <= 7'd100)
    else $error("result field out of range");

  a_switch: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.switch_on == (res.red == 8'hFF || res.green == 8'hFF ||
                                    res.blue == 8'hFF || res.white == 8'hFF))
    else $error("switch flag does not match values");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.red == res.green && res.green == res.blue |->
      res.hue_deg == '0 && res.sat_intensity_pct == '0 && res.sat_value_pct == '0)
    else $error("grey frame with hue or saturation");

endmodule

bind rgb_to_hsv_hsi_change_filter rhsv_check u_check (.*);
